/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define OATT_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define OATT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  `OATT_ASSERT(label, clk, rstn, (ante) |-> (cons), msg)

// Next-cycle implication.
`define OATT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  `OATT_ASSERT(label, clk, rstn, (ante) |=> (cons), msg)

`endif

/* hw/rtl/oatt_pkg.sv */
// Package with the constants, types and helpers of the timestamp tracker.
package oatt_pkg;

  localparam int TableDepth = 16;
  localparam int StampW     = 64;
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int LiveW      = 5;
  localparam int StatusW    = 2;
  localparam int ResFieldW  = StampW + LiveW + StatusW;
  localparam int OutDataW   = ((ResFieldW + 7) / 8) * 8;
  localparam int OutPadW    = OutDataW - ResFieldW;

  typedef enum logic {
    OpInsert = 1'b0,
    OpErase  = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk     = 2'd0,
    StatusAbsent = 2'd1,
    StatusFull   = 2'd2,
    StatusOrder  = 2'd3
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [StampW-1:0] stamp;
  } tbl_req_t;

  typedef struct packed {
    logic [StampW-1:0] oldest;
    logic [CntW-1:0]   count;
    status_e           status;
  } tbl_res_t;

  // Increment that sticks at the all-ones value.
  function automatic logic [StampW-1:0] sat_inc(input logic [StampW-1:0] v);
    logic [StampW-1:0] r;
    r = (&v) ? v : v + StampW'(1);
    return r;
  endfunction

endpackage

/* hw/rtl/oatt_table.sv */
// Sorted table of active timestamps with insert and erase.
module oatt_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              apply_i,
  input  oatt_pkg::tbl_req_t req_i,
  output oatt_pkg::tbl_res_t res_o
);

  localparam int Depth = oatt_pkg::TableDepth;
  localparam int SW    = oatt_pkg::StampW;
  localparam int CW    = oatt_pkg::CntW;

  logic [SW-1:0]    entry_q [Depth];
  logic [SW-1:0]    entry_d [Depth];
  logic [Depth-1:0] entry_we;
  logic [Depth-1:0] valid_q, valid_d;
  logic [SW-1:0]    last_q, last_d;
  logic [SW-1:0]    oldest_q, oldest_d;
  logic [CW-1:0]    count_q, count_d;
  logic [Depth-1:0] match;
  logic [Depth-1:0] shift_en;
  logic             hit;
  oatt_pkg::status_e status;

  // Parallel match; the table is strictly increasing so at most one slot hits.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      match[i]    = valid_q[i] && (entry_q[i] == req_i.stamp);
      shift_en[i] = |(match & ({Depth{1'b1}} >> (Depth - 1 - i)));
    end
    hit = |match;
  end

  always_comb begin
    valid_d  = valid_q;
    last_d   = last_q;
    oldest_d = oldest_q;
    count_d  = count_q;
    status   = oatt_pkg::StatusOk;
    entry_we = '0;
    for (int i = 0; i < Depth; i++) begin
      entry_d[i] = entry_q[i];
    end
    unique case (req_i.op)
      oatt_pkg::OpInsert: begin
        if (valid_q[Depth-1]) begin
          status = oatt_pkg::StatusFull;
        end else if (!valid_q[0] && (req_i.stamp < oldest_q)) begin
          status = oatt_pkg::StatusOrder;
        end else if (valid_q[0] && (req_i.stamp <= last_q)) begin
          status = oatt_pkg::StatusOrder;
        end else begin
          if (!valid_q[0]) begin
            oldest_d = req_i.stamp;
          end
          // The new entry lands in the first free slot after the valid prefix.
          for (int i = 0; i < Depth; i++) begin
            if (!valid_q[i] && ((i == 0) || valid_q[(i == 0) ? 0 : i - 1])) begin
              entry_we[i] = 1'b1;
              entry_d[i]  = req_i.stamp;
            end
          end
          valid_d = {valid_q[Depth-2:0], 1'b1};
          last_d  = req_i.stamp;
          count_d = count_q + CW'(1);
        end
      end
      oatt_pkg::OpErase: begin
        if (!hit) begin
          status = oatt_pkg::StatusAbsent;
        end else begin
          if (match[0]) begin
            oldest_d = valid_q[1] ? entry_q[1] : oatt_pkg::sat_inc(last_q);
          end
          // Close the gap: each slot from the hit up to the next-to-top slot takes its upper neighbor.
          for (int i = 0; i < Depth - 1; i++) begin
            if (shift_en[i]) begin
              entry_we[i] = 1'b1;
              entry_d[i]  = entry_q[i+1];
            end
          end
          valid_d = {1'b0, valid_q[Depth-1:1]};
          count_d = count_q - CW'(1);
        end
      end
      default: begin
        status = oatt_pkg::StatusOk;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      if (apply_i && entry_we[i]) begin
        entry_q[i] <= entry_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      last_q   <= '0;
      oldest_q <= '0;
      count_q  <= '0;
    end else if (apply_i) begin
      valid_q  <= valid_d;
      last_q   <= last_d;
      oldest_q <= oldest_d;
      count_q  <= count_d;
    end
  end

  assign res_o.oldest = oldest_d;
  assign res_o.count  = count_d;
  assign res_o.status = status;

endmodule

/* hw/rtl/oldest_active_timestamp_tracker_top.sv */
// Top level of the oldest-active-timestamp tracker with stream ports.
// A request passes from the input register through the table into the result register on the master side.
// Throughput: one request per cycle while the result side is not stalled.
// Reset (rst_ni low, asynchronous) empties the table and zeroes the oldest and last stamps.
// Stored stamps are not cleared by reset; only valid slots are ever read.
module oldest_active_timestamp_tracker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request side.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [oatt_pkg::StampW-1:0]   s_axis_tdata_i,   // [63:0] stamp
  input  logic [0:0]                    s_axis_tuser_i,   // [0] operation (0 insert, 1 erase)
  // Result side.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [oatt_pkg::OutDataW-1:0] m_axis_tdata_o    // [63:0] oldest_stamp,
                                                          // [68:64] live_count,
                                                          // [70:69] status, [71] zero
);

  // Input register: holds one request while the table works on it.
  logic                        in_vld_q;
  oatt_pkg::tbl_req_t          in_req_q;
  // Result register: parts the table from a stalled consumer.
  logic                        out_vld_q;
  logic [oatt_pkg::StampW-1:0] out_oldest_q;
  logic [oatt_pkg::LiveW-1:0]  out_live_q;
  oatt_pkg::status_e           out_status_q;

  logic                        advance;
  oatt_pkg::tbl_res_t          tbl_res;

  // The held request moves on when the result register is free or being emptied.
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_req_q.op    <= oatt_pkg::op_e'(s_axis_tuser_i[0]);
      in_req_q.stamp <= s_axis_tdata_i;
    end
  end

  // The table commits its state change in the same cycle the result is captured.
  oatt_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .apply_i (advance),
    .req_i   (in_req_q),
    .res_o   (tbl_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // The live count is reported masked to the width of its field.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_oldest_q <= tbl_res.oldest;
      out_live_q   <= oatt_pkg::LiveW'(tbl_res.count);
      out_status_q <= tbl_res.status;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{oatt_pkg::OutPadW{1'b0}}, out_status_q, out_live_q, out_oldest_q};

endmodule

/* hw/rtl/oatt_checker.sv */
// Port-level checker for the timestamp tracker, bound to the top level.
`include "assert_macros.svh"

module oatt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [oatt_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int SW = oatt_pkg::StampW;
  localparam int LW = oatt_pkg::LiveW;
  localparam logic [LW-1:0] FullLive = LW'(oatt_pkg::TableDepth);

  logic [LW-1:0]                  live;
  logic [oatt_pkg::StatusW-1:0]   status;
  logic [LW-1:0]                  prev_live_q;
  logic                           have_prev_q;
  logic                           out_stall;
  logic                           full_seen;
  logic                           reject_seen;
  logic                           ok_seen;
  logic                           count_step;

  assign live   = m_axis_tdata_o[SW+LW-1:SW];
  assign status = m_axis_tdata_o[SW+LW+oatt_pkg::StatusW-1:SW+LW];

  // A result is offered and the consumer holds it off.
  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign full_seen   = m_axis_tvalid_o && (status == oatt_pkg::StatusFull);
  // Rejected and accepted requests are judged against the previous result.
  assign reject_seen = m_axis_tvalid_o && have_prev_q && (status != oatt_pkg::StatusOk);
  assign ok_seen     = m_axis_tvalid_o && have_prev_q && (status == oatt_pkg::StatusOk);
  assign count_step  = (live == LW'(prev_live_q + LW'(1))) || (live == LW'(prev_live_q - LW'(1)));

  // Count of the last delivered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_live_q <= '0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      have_prev_q <= 1'b1;
      prev_live_q <= live;
    end
  end

  `OATT_ASSERT_NXT(a_hold_valid, clk_i, rst_ni, out_stall, m_axis_tvalid_o, "result dropped")

  `OATT_ASSERT_NXT(a_hold_data, clk_i, rst_ni, out_stall, $stable(m_axis_tdata_o), "data changed")

  `OATT_ASSERT_IMP(a_full_count, clk_i, rst_ni, full_seen, live == FullLive, "full below depth")

  `OATT_ASSERT_IMP(a_reject_keeps, clk_i, rst_ni, reject_seen, live == prev_live_q, "count moved")

  `OATT_ASSERT_IMP(a_ok_steps, clk_i, rst_ni, ok_seen, count_step, "count not stepped")

endmodule

bind oldest_active_timestamp_tracker_top oatt_checker u_oatt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
